// ===== src/hgb_pkg.sv =====
package hgb_pkg;

    localparam int COORD_W = 16;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 16;
    localparam int SIZE_W  = 10;
    localparam int OFS_W   = 15;
    localparam int GRID_W  = 7;
    localparam int QUOT_W  = 17;
    localparam int SUM_W   = 18;
    localparam int PROD_W  = 2 * GRID_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int WORD_W  = CNT_W + 2 * COORD_W;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = 16'hFFFF;

    localparam logic [SIZE_W-1:0] CELL_SIZE_RESET   = 10'd100;
    localparam logic [OFS_W-1:0]  BACK_OFFSET_RESET = 15'd800;
    localparam logic [OFS_W-1:0]  SIDE_OFFSET_RESET = 15'd2000;
    localparam logic [GRID_W-1:0] GRID_WIDTH_RESET  = 7'd48;
    localparam logic [GRID_W-1:0] GRID_HEIGHT_RESET = 7'd40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SIZE   = 3'd0,
        CFG_BACK_OFFSET = 3'd1,
        CFG_SIDE_OFFSET = 3'd2,
        CFG_GRID_WIDTH  = 3'd3,
        CFG_GRID_HEIGHT = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_INDEX  = 6'b001000,
        ST_READ   = 6'b010000,
        ST_MODIFY = 6'b100000
    } state_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] col;
        logic [QUOT_W-1:0] row;
    } quot_t;

endpackage

// ===== src/hgb_ram.sv =====
module hgb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hgb_div.sv =====
module hgb_div
    import hgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [QUOT_W-1:0] num_col,
    input  logic [QUOT_W-1:0] num_row,
    input  logic [SIZE_W-1:0] divisor,
    output quot_t             quot
);

    localparam int STEP_W = $clog2(QUOT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SIZE_W-1:0] div_reg;
    logic [QUOT_W-1:0] qc_reg, qc_next, qr_reg, qr_next;
    logic [SIZE_W-1:0] rc_reg, rc_next, rr_reg, rr_next;
    logic [SIZE_W:0]   rc_sh, rr_sh, dc, dr;

    // restoring division, one quotient bit per lane each cycle
    always_comb
    begin
        rc_sh = {rc_reg, qc_reg[QUOT_W-1]};
        rr_sh = {rr_reg, qr_reg[QUOT_W-1]};
        dc = rc_sh - {1'b0, div_reg};
        dr = rr_sh - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        qc_next = qc_reg;
        qr_next = qr_reg;
        rc_next = rc_reg;
        rr_next = rr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            qc_next = num_col;
            qr_next = num_row;
            rc_next = '0;
            rr_next = '0;
        end
        else if (busy_reg)
        begin
            qc_next = {qc_reg[QUOT_W-2:0], ~dc[SIZE_W]};
            qr_next = {qr_reg[QUOT_W-2:0], ~dr[SIZE_W]};
            rc_next = dc[SIZE_W] ? rc_sh[SIZE_W-1:0] : dc[SIZE_W-1:0];
            rr_next = dr[SIZE_W] ? rr_sh[SIZE_W-1:0] : dr[SIZE_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
        end
        qc_reg <= qc_next;
        qr_reg <= qr_next;
        rc_reg <= rc_next;
        rr_reg <= rr_next;
    end

    assign quot.done = done_reg;
    assign quot.col  = qc_reg;
    assign quot.row  = qr_reg;

endmodule

// ===== src/height_grid_binner_unit.sv =====
// Height grid binner. Add-point transactions are binned by
// floor((x + back) / cell) and floor((y + side) / cell) into a grid of
// per-cell count, minimum and maximum height held in one synchronous RAM of
// MAX_WIDTH * MAX_HEIGHT words; read transactions return a cell and clear it.
// One transaction is worked at a time. A kept point holds s_tready low while
// the bit-serial divider finds column and row (17 quotient steps and its done
// flag), through the cell index multiply and through the RAM read-modify-write.
// A point off the grid holds it low through division and the index step, a
// point dropped before division not at all, and a read through the RAM read
// and write, plus any wait for the output register to free.
// After reset the RAM is cleared one word per cycle, with s_tready low until all
// MAX_WIDTH * MAX_HEIGHT words are cleared; configuration writes are taken then.
// A finished read result waits in an output register while the next
// transaction is accepted.
module height_grid_binner_unit
    import hgb_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // x_mm, y_mm, z_mm, cell_index, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode, point_finite
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cell_count, cell_min_mm, cell_max_mm
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] cell_size_reg;
    logic [OFS_W-1:0]  back_offset_reg, side_offset_reg;
    logic [GRID_W-1:0] grid_width_reg, grid_height_reg;
    logic [GRID_W-1:0] w_eff, h_eff;
    logic [SIZE_W-1:0] divisor;

    logic [AW-1:0] clr_addr_reg;
    logic          op_reg;
    logic          in_range_reg, in_range_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic signed [COORD_W-1:0] z_reg;

    logic accept, is_read, finite;
    logic signed [COORD_W-1:0] x_in, y_in, z_in;
    logic [IDX_W-1:0] cell_index_in;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic div_start;
    quot_t quot;

    logic [PROD_W-1:0] cell_idx;
    logic [31:0] cell_idx32, read_idx32;
    logic col_ok, row_ok;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata, mod_word;
    logic [CNT_W-1:0]  rd_cnt, new_cnt;
    logic signed [COORD_W-1:0] rd_min, rd_max, new_min, new_max;

    logic out_free, out_load;
    logic m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0] out_cnt_reg;
    logic signed [COORD_W-1:0] out_min_reg, out_max_reg;

    assign w_eff = (32'(grid_width_reg) > MAX_WIDTH) ? GRID_W'(MAX_WIDTH) : grid_width_reg;
    assign h_eff = (32'(grid_height_reg) > MAX_HEIGHT) ? GRID_W'(MAX_HEIGHT) : grid_height_reg;
    assign divisor = (cell_size_reg == '0) ? SIZE_W'(1) : cell_size_reg;

    assign x_in = s_tdata[15:0];
    assign y_in = s_tdata[31:16];
    assign z_in = s_tdata[47:32];
    assign cell_index_in = s_tdata[59:48];
    assign is_read = (s_tuser[0] == OP_READ);
    assign finite = s_tuser[1];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;

    assign sum_x = SUM_W'(x_in) + SUM_W'(back_offset_reg);
    assign sum_y = SUM_W'(y_in) + SUM_W'(side_offset_reg);

    // negative sums floor to a negative cell and are dropped here
    assign div_start = accept && !is_read && finite && !sum_x[SUM_W-1] && !sum_y[SUM_W-1];

    hgb_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_col (QUOT_W'(sum_x)),
        .num_row (QUOT_W'(sum_y)),
        .divisor (divisor),
        .quot    (quot)
    );

    assign col_ok = (quot.col < QUOT_W'(w_eff));
    assign row_ok = (quot.row < QUOT_W'(h_eff));
    assign cell_idx = PROD_W'(quot.row[GRID_W-1:0]) * PROD_W'(w_eff)
                    + PROD_W'(quot.col[GRID_W-1:0]);
    assign cell_idx32 = 32'(cell_idx);
    assign read_idx32 = 32'(cell_index_in);

    assign rd_cnt = ram_rdata[CNT_W-1:0];
    assign rd_min = ram_rdata[CNT_W +: COORD_W];
    assign rd_max = ram_rdata[CNT_W + COORD_W +: COORD_W];

    always_comb
    begin
        if (rd_cnt == '0)
        begin
            new_min = z_reg;
            new_max = z_reg;
        end
        else
        begin
            new_min = (z_reg < rd_min) ? z_reg : rd_min;
            new_max = (z_reg > rd_max) ? z_reg : rd_max;
        end
        new_cnt = (rd_cnt == COUNT_LIMIT) ? rd_cnt : rd_cnt + 1'b1;
        mod_word = (op_reg == OP_READ) ? '0 : {new_max, new_min, new_cnt};
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_MODIFY) && (op_reg == OP_READ) && out_free;

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        in_range_next = in_range_reg;
        ram_we = 1'b0;
        ram_re = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && is_read)
                begin
                    in_range_next = (read_idx32 < STORE_DEPTH);
                    addr_next = read_idx32[AW-1:0];
                    state_next = ST_READ;
                end
                else if (div_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (quot.done)
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                in_range_next = col_ok && row_ok && (cell_idx32 < STORE_DEPTH);
                addr_next = cell_idx32[AW-1:0];
                state_next = (col_ok && row_ok) ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (op_reg == OP_ADD || out_free)
                begin
                    ram_we = in_range_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : mod_word;

    hgb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
            cell_size_reg   <= CELL_SIZE_RESET;
            back_offset_reg <= BACK_OFFSET_RESET;
            side_offset_reg <= SIDE_OFFSET_RESET;
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CELL_SIZE:   cell_size_reg   <= cfg_wdata[SIZE_W-1:0];
                    CFG_BACK_OFFSET: back_offset_reg <= cfg_wdata[OFS_W-1:0];
                    CFG_SIDE_OFFSET: side_offset_reg <= cfg_wdata[OFS_W-1:0];
                    CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[GRID_W-1:0];
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[GRID_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        in_range_reg <= in_range_next;
        if (accept)
        begin
            op_reg <= s_tuser[0];
            z_reg  <= z_in;
        end
        if (out_load)
        begin
            if (in_range_reg && rd_cnt != '0)
            begin
                out_cnt_reg <= rd_cnt;
                out_min_reg <= rd_min;
                out_max_reg <= rd_max;
            end
            else
            begin
                out_cnt_reg <= in_range_reg ? rd_cnt : '0;
                out_min_reg <= '0;
                out_max_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_max_reg, out_min_reg, out_cnt_reg};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import hgb_pkg::*;

    localparam int GRID_MAX_W = 64;
    localparam int GRID_MAX_H = 64;
    localparam int CELLS = GRID_MAX_W * GRID_MAX_H;
    localparam int STALL_LIMIT = 50000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [CNT_W-1:0]   count;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } cell_rec_t;

    class grid_cell_tracker;
        int cell_size;
        int back;
        int side;
        int width;
        int height;
        int unsigned hits[CELLS];
        int lo_z[CELLS];
        int hi_z[CELLS];
        cell_rec_t cells_due[$];
        int errors;

        function new();
            cell_size = int'(CELL_SIZE_RESET);
            back = int'(BACK_OFFSET_RESET);
            side = int'(SIDE_OFFSET_RESET);
            width = int'(GRID_WIDTH_RESET);
            height = int'(GRID_HEIGHT_RESET);
            errors = 0;
            foreach (hits[i])
            begin
                hits[i] = 0;
                lo_z[i] = 0;
                hi_z[i] = 0;
            end
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CELL_SIZE:   cell_size = int'(val[SIZE_W-1:0]);
                CFG_BACK_OFFSET: back = int'(val[OFS_W-1:0]);
                CFG_SIDE_OFFSET: side = int'(val[OFS_W-1:0]);
                CFG_GRID_WIDTH:  width = int'(val[GRID_W-1:0]);
                CFG_GRID_HEIGHT: height = int'(val[GRID_W-1:0]);
                default: ;
            endcase
        endfunction

        function int eff_width();
            return (width > GRID_MAX_W) ? GRID_MAX_W : width;
        endfunction

        function int eff_height();
            return (height > GRID_MAX_H) ? GRID_MAX_H : height;
        endfunction

        function int divisor();
            return (cell_size == 0) ? 1 : cell_size;
        endfunction

        function int floor_div(int v, int d);
            int q;
            q = v / d;
            if (v < 0 && q * d != v)
                q = q - 1;
            return q;
        endfunction

        // cell index a point lands in, or -1 when it falls off the grid
        function int locate_cell(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
            int gx;
            int gy;
            gx = floor_div(int'(x) + back, divisor());
            gy = floor_div(int'(y) + side, divisor());
            if (gx < 0 || gy < 0 || gx >= eff_width() || gy >= eff_height())
                return -1;
            if (gy * eff_width() + gx >= CELLS)
                return -1;
            return gy * eff_width() + gx;
        endfunction

        function void take_item(opcode_t op, logic finite, logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                                logic [IDX_W-1:0] cidx);
            int idx;
            cell_rec_t rec;
            if (op == OP_ADD)
            begin
                if (!finite)
                    return;
                idx = locate_cell(x, y);
                if (idx < 0)
                    return;
                if (hits[idx] == 0)
                begin
                    lo_z[idx] = int'(z);
                    hi_z[idx] = int'(z);
                end
                else
                begin
                    if (int'(z) < lo_z[idx])
                        lo_z[idx] = int'(z);
                    if (int'(z) > hi_z[idx])
                        hi_z[idx] = int'(z);
                end
                if (hits[idx] < COUNT_LIMIT)
                    hits[idx] = hits[idx] + 1;
            end
            else
            begin
                idx = int'(cidx);
                rec.count = '0;
                rec.lo = '0;
                rec.hi = '0;
                if (idx < CELLS)
                begin
                    rec.count = CNT_W'(hits[idx]);
                    if (hits[idx] != 0)
                    begin
                        rec.lo = COORD_W'(lo_z[idx]);
                        rec.hi = COORD_W'(hi_z[idx]);
                    end
                    hits[idx] = 0;
                end
                cells_due.push_back(rec);
            end
        endfunction

        function void check_cell(logic [OUT_DATA_W-1:0] data);
            cell_rec_t want;
            if (cells_due.size() == 0)
            begin
                $error("cell result with none expected: %h", data);
                errors++;
                return;
            end
            want = cells_due.pop_front();
            if (data[15:0] !== want.count)
            begin
                $error("cell_count: expected %0d, actual %0d", want.count, data[15:0]);
                errors++;
            end
            if (data[31:16] !== want.lo)
            begin
                $error("cell_min_mm: expected %0d, actual %0d", $signed(want.lo),
                       $signed(data[31:16]));
                errors++;
            end
            if (data[47:32] !== want.hi)
            begin
                $error("cell_max_mm: expected %0d, actual %0d", $signed(want.hi),
                       $signed(data[47:32]));
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // x_mm, y_mm, z_mm, cell_index, zero fill
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // opcode, point_finite
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // cell_count, cell_min_mm, cell_max_mm
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    grid_cell_tracker tracker = new();
    bit calm = 1'b0;
    bit sender_gaps = 1'b0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;
    int hot_col[4];
    int hot_row[4];

    height_grid_binner_unit #(
        .MAX_WIDTH  (GRID_MAX_W),
        .MAX_HEIGHT (GRID_MAX_H)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_cell(m_tdata);
            if (hold_off)
            begin
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_item(opcode_t op, logic finite, logic [COORD_W-1:0] x,
                             logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                             logic [IDX_W-1:0] cidx);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tdata <= {4'b0, cidx, z, y, x};
        s_tuser <= {finite, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.take_item(op, finite, x, y, z, cidx);
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        tracker.set_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(int csz, int bk, int sd, int w, int h);
        write_reg(CFG_CELL_SIZE, csz);
        write_reg(CFG_BACK_OFFSET, bk);
        write_reg(CFG_SIDE_OFFSET, sd);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // wait out every pending read and the longest add in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.cells_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_items(int n, int read_pct);
        int r;
        int k;
        int w;
        int h;
        int d;
        int gx;
        int gy;
        int xv;
        int yv;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 3);
            w = (tracker.eff_width() == 0) ? GRID_MAX_W : tracker.eff_width();
            h = (tracker.eff_height() == 0) ? GRID_MAX_H : tracker.eff_height();
            if (r < read_pct)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_item(OP_READ, 1'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 12'(hot_row[k] * w + hot_col[k]));
                else
                    send_item(OP_READ, 1'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 12'($urandom));
            end
            else if (r < read_pct + 10)
                send_item(OP_ADD, 1'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 12'($urandom));
            else
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    gx = hot_col[k];
                    gy = hot_row[k];
                end
                else
                begin
                    gx = $urandom_range(0, w - 1);
                    gy = $urandom_range(0, h - 1);
                end
                d = tracker.divisor();
                xv = gx * d - tracker.back + $urandom_range(0, d - 1);
                yv = gy * d - tracker.side + $urandom_range(0, d - 1);
                xs = (xv < -32768 || xv > 32767) ? 16'($urandom) : xv[15:0];
                ys = (yv < -32768 || yv > 32767) ? 16'($urandom) : yv[15:0];
                send_item(OP_ADD, 1'b1, xs, ys, 16'($urandom), 12'($urandom));
            end
        end
    endtask

    task automatic run_phase(int csz, int bk, int sd, int w, int h, int n, int read_pct,
                             bit squeeze);
        int aw;
        int ah;
        drain();
        configure(csz, bk, sd, w, h);
        aw = (tracker.eff_width() == 0) ? GRID_MAX_W : tracker.eff_width();
        ah = (tracker.eff_height() == 0) ? GRID_MAX_H : tracker.eff_height();
        foreach (hot_col[i])
        begin
            hot_col[i] = $urandom_range(0, aw - 1);
            hot_row[i] = $urandom_range(0, ah - 1);
        end
        sender_gaps = !calm && ($urandom_range(0, 3) != 0);
        if (squeeze)
        begin
            // results back up behind a stalled receiver
            hold_off = 1'b1;
            repeat (16)
                send_item(OP_READ, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                          12'($urandom));
        end
        random_items(n, read_pct);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // default grid: 100 mm cells, col 8 row 20 holds the origin
        configure(100, 800, 2000, 48, 40);
        send_item(OP_ADD, 1'b1, 16'sd0, 16'sd0, 16'sd100, 12'hFFF);
        send_item(OP_ADD, 1'b1, 16'sd50, 16'sd99, -16'sd32768, 12'h000);
        send_item(OP_ADD, 1'b1, 16'sd0, 16'sd0, 16'sd32767, 12'hABC);
        send_item(OP_ADD, 1'b0, 16'sd0, 16'sd0, 16'sd5, 12'd968);
        // one mm behind the grid: floors to column -1
        send_item(OP_ADD, 1'b1, -16'sd801, 16'sd0, 16'sd7, 12'd960);
        send_item(OP_ADD, 1'b1, -16'sd800, -16'sd2000, 16'sd1, 12'h555);
        send_item(OP_ADD, 1'b1, 16'sd3999, 16'sd1999, -16'sd1, 12'h0);
        send_item(OP_ADD, 1'b1, 16'sd4000, 16'sd0, 16'sd9, 12'h0);
        send_item(OP_ADD, 1'b1, 16'sd0, 16'sd2000, 16'sd9, 12'h0);
        send_item(OP_ADD, 1'b1, 16'sd32767, 16'sd32767, 16'sd3, 12'h0);
        send_item(OP_ADD, 1'b1, -16'sd32768, -16'sd32768, 16'sd3, 12'h0);
        send_item(OP_READ, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd968);
        send_item(OP_READ, 1'b0, 16'h0, 16'h0, 16'h0, 12'd968);
        send_item(OP_READ, 1'b1, 16'h8000, 16'h7FFF, 16'h1234, 12'd0);
        send_item(OP_READ, 1'b0, 16'h0, 16'h0, 16'h0, 12'd1919);
        send_item(OP_READ, 1'b0, 16'h0, 16'h0, 16'h0, 12'd960);
        send_item(OP_READ, 1'b0, 16'h0, 16'h0, 16'h0, 12'd4095);

        run_phase(1, 0, 0, 64, 64, 110, 30, 1'b0);
        // zero cell size and oversized grid
        run_phase(0, 32767, 32767, 127, 127, 110, 30, 1'b0);
        run_phase(1000, 0, 32767, 64, 64, 100, 30, 1'b0);
        run_phase(3, 100, 100, 0, 40, 50, 40, 1'b0);
        run_phase(3, 100, 100, 20, 0, 50, 40, 1'b0);
        run_phase($urandom_range(1, 1000), $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(1, 64), $urandom_range(1, 64), 100, 35, 1'b1);
        calm = 1'b1;
        run_phase($urandom_range(1, 120), $urandom_range(0, 4000), $urandom_range(0, 4000),
                  $urandom_range(1, 64), $urandom_range(1, 64), 120, 30, 1'b0);

        s_tvalid <= 1'b0;
        while (tracker.cells_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.errors == 0 && tracker.cells_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
src/hgb_pkg.sv
src/hgb_ram.sv
src/hgb_div.sv
src/height_grid_binner_unit.sv
verif/testbench.sv
